### design/mlprq_pkg.sv
package mlprq_pkg;

    localparam int MAX_TASKS_DEF      = 64;
    localparam int NUM_PRIORITIES_DEF = 8;
    localparam int NUM_STATES_DEF     = 4;

    localparam int ACTION_W   = 2;
    localparam int TASK_W     = 6;
    localparam int STATE_W    = 2;
    localparam int PRIORITY_W = 3;
    localparam int STATUS_W   = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_REMOVE  = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_NOT_QUEUED = 2'd2,
        ST_ALREADY    = 2'd3
    } t_status;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [TASK_W-1:0]     task_id;
        logic [STATE_W-1:0]    state_select;
        logic [PRIORITY_W-1:0] priority_level;
    } t_req;

    typedef struct packed {
        logic [TASK_W-1:0]   result_task;
        logic [STATUS_W-1:0] status;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_STEP = 4'b0100,
        S_DONE = 4'b1000
    } t_seq_state;

endpackage

### design/mlprq_stream_if.sv
interface mlprq_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/mlprq_ram.sv
module mlprq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 7,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/mlprq_ctrl.sv
module mlprq_ctrl #(
    parameter int MAX_TASKS      = mlprq_pkg::MAX_TASKS_DEF,
    parameter int NUM_PRIORITIES = mlprq_pkg::NUM_PRIORITIES_DEF,
    parameter int NUM_STATES     = mlprq_pkg::NUM_STATES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  mlprq_pkg::t_req i_req,
    input  logic            i_out_free,
    output logic            o_idle,
    output logic            o_done,
    output mlprq_pkg::t_rsp o_rsp
);
    localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int KW = $clog2(MAX_TASKS + 1);
    localparam int NL = NUM_STATES * NUM_PRIORITIES;
    localparam int LW = (NL > 1) ? $clog2(NL) : 1;
    localparam logic [KW-1:0] LNULL = KW'(MAX_TASKS);

    mlprq_pkg::t_seq_state r_state, n_state;
    mlprq_pkg::t_req       r_req, n_req;
    mlprq_pkg::t_rsp       r_rsp, n_rsp;
    logic [TW-1:0]         r_tid, n_tid;
    logic [LW-1:0]         r_li, n_li;
    logic [KW-1:0]         r_tail, n_tail;
    logic [TW-1:0]         r_task, n_task;
    logic [MAX_TASKS-1:0]  r_linked, n_linked;
    logic [NL-1:0]         r_nonempty, n_nonempty;

    logic          nx_we, pv_we, hl_we;
    logic [TW-1:0] nx_waddr, nx_raddr, pv_waddr, pv_raddr;
    logic [KW-1:0] nx_wdata, nx_rdata, pv_wdata, pv_rdata;
    logic [LW-1:0] hl_waddr, hl_raddr;
    logic [2*KW-1:0] hl_wdata, hl_rdata;

    mlprq_ram #(.DEPTH(MAX_TASKS), .WIDTH(KW)) u_next (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_raddr (nx_raddr),
        .o_rdata (nx_rdata)
    );

    mlprq_ram #(.DEPTH(MAX_TASKS), .WIDTH(KW)) u_prev (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_raddr (pv_raddr),
        .o_rdata (pv_rdata)
    );

    mlprq_ram #(.DEPTH(NL), .WIDTH(2 * KW)) u_head_tail (
        .i_clk   (i_clk),
        .i_we    (hl_we),
        .i_waddr (hl_waddr),
        .i_wdata (hl_wdata),
        .i_raddr (hl_raddr),
        .o_rdata (hl_rdata)
    );

    always_comb begin
        int            st_sat;
        int            pr_sat;
        int            base;
        logic          found;
        logic [LW-1:0] deq_li;
        logic [LW-1:0] req_li;
        logic          tid_ok;
        logic [TW-1:0] tid_t;
        logic [KW-1:0] head;
        logic [KW-1:0] tail;
        logic [KW-1:0] p;
        logic [KW-1:0] n;
        logic [KW-1:0] r_tid_k;
        logic [KW-1:0] new_head;
        logic [KW-1:0] new_tail;
        logic          p_is;
        logic          n_is;
        logic          bad;

        n_state    = r_state;
        n_req      = r_req;
        n_rsp      = r_rsp;
        n_tid      = r_tid;
        n_li       = r_li;
        n_tail     = r_tail;
        n_task     = r_task;
        n_linked   = r_linked;
        n_nonempty = r_nonempty;
        o_done     = 1'b0;

        nx_we    = 1'b0;
        nx_waddr = r_tid;
        nx_wdata = LNULL;
        nx_raddr = r_tid;
        pv_we    = 1'b0;
        pv_waddr = r_tid;
        pv_wdata = LNULL;
        pv_raddr = r_tid;
        hl_we    = 1'b0;
        hl_waddr = r_li;
        hl_wdata = {LNULL, LNULL};
        hl_raddr = r_li;

        st_sat = (int'(i_req.state_select) >= NUM_STATES) ? NUM_STATES - 1
                                                           : int'(i_req.state_select);
        pr_sat = (int'(i_req.priority_level) >= NUM_PRIORITIES) ? NUM_PRIORITIES - 1
                                                                : int'(i_req.priority_level);
        base   = st_sat * NUM_PRIORITIES;
        req_li = LW'(base + pr_sat);
        tid_ok = int'(i_req.task_id) < MAX_TASKS;
        tid_t  = TW'(int'(i_req.task_id));

        found  = 1'b0;
        deq_li = LW'(base);
        for (int q = NUM_PRIORITIES - 1; q >= 0; q--) begin
            if (r_nonempty[LW'(base + q)]) begin
                found  = 1'b1;
                deq_li = LW'(base + q);
            end
        end

        head     = r_nonempty[r_li] ? hl_rdata[2*KW-1:KW] : LNULL;
        tail     = r_nonempty[r_li] ? hl_rdata[KW-1:0] : LNULL;
        p        = pv_rdata;
        n        = nx_rdata;
        p_is     = p < LNULL;
        n_is     = n < LNULL;
        r_tid_k  = KW'(r_tid);
        bad      = (!p_is && head != r_tid_k) || (!n_is && tail != r_tid_k);
        new_head = p_is ? head : n;
        new_tail = n_is ? tail : p;

        unique case (r_state)
            mlprq_pkg::S_IDLE: begin
                if (i_start) begin
                    n_req             = i_req;
                    n_tid             = tid_t;
                    n_li              = req_li;
                    n_rsp.result_task = i_req.task_id;
                    n_rsp.status      = mlprq_pkg::ST_OK;
                    n_state           = mlprq_pkg::S_DONE;
                    nx_raddr          = tid_t;
                    pv_raddr          = tid_t;
                    hl_raddr          = req_li;
                    unique case (i_req.action)
                        mlprq_pkg::ACT_ENQUEUE: begin
                            if (!tid_ok) begin
                                n_rsp.status = mlprq_pkg::ST_NOT_QUEUED;
                            end else if (r_linked[tid_t]) begin
                                n_rsp.status = mlprq_pkg::ST_ALREADY;
                            end else begin
                                n_state = mlprq_pkg::S_READ;
                            end
                        end
                        mlprq_pkg::ACT_REMOVE: begin
                            if (!tid_ok || !r_linked[tid_t]) begin
                                n_rsp.status = mlprq_pkg::ST_NOT_QUEUED;
                            end else begin
                                n_state = mlprq_pkg::S_READ;
                            end
                        end
                        mlprq_pkg::ACT_DEQUEUE: begin
                            if (!found) begin
                                n_rsp.result_task = '0;
                                n_rsp.status      = mlprq_pkg::ST_EMPTY;
                            end else begin
                                n_li     = deq_li;
                                hl_raddr = deq_li;
                                n_state  = mlprq_pkg::S_READ;
                            end
                        end
                        mlprq_pkg::ACT_NONE: begin
                            n_state = mlprq_pkg::S_DONE;
                        end
                    endcase
                end
            end
            mlprq_pkg::S_READ: begin
                unique case (r_req.action)
                    mlprq_pkg::ACT_ENQUEUE: begin
                        pv_we              = 1'b1;
                        pv_waddr           = r_tid;
                        pv_wdata           = tail;
                        nx_we              = 1'b1;
                        nx_waddr           = r_tid;
                        nx_wdata           = LNULL;
                        hl_we              = 1'b1;
                        hl_wdata           = {(r_nonempty[r_li] ? head : r_tid_k), r_tid_k};
                        n_nonempty[r_li]   = 1'b1;
                        n_linked[r_tid]    = 1'b1;
                        n_tail             = tail;
                        n_state            = r_nonempty[r_li] ? mlprq_pkg::S_STEP
                                                              : mlprq_pkg::S_DONE;
                    end
                    mlprq_pkg::ACT_REMOVE: begin
                        n_state = mlprq_pkg::S_DONE;
                        if (bad) begin
                            n_rsp.status = mlprq_pkg::ST_NOT_QUEUED;
                        end else begin
                            nx_we            = p_is;
                            nx_waddr         = TW'(p);
                            nx_wdata         = n;
                            pv_we            = n_is;
                            pv_waddr         = TW'(n);
                            pv_wdata         = p;
                            hl_we            = 1'b1;
                            hl_wdata         = {new_head, new_tail};
                            n_nonempty[r_li] = new_head < LNULL;
                            n_linked[r_tid]  = 1'b0;
                        end
                    end
                    mlprq_pkg::ACT_DEQUEUE: begin
                        n_task   = TW'(head);
                        nx_raddr = TW'(head);
                        n_tail   = tail;
                        n_state  = mlprq_pkg::S_STEP;
                    end
                    mlprq_pkg::ACT_NONE: begin
                        n_state = mlprq_pkg::S_DONE;
                    end
                endcase
            end
            mlprq_pkg::S_STEP: begin
                n_state = mlprq_pkg::S_DONE;
                priority if (r_req.action == mlprq_pkg::ACT_ENQUEUE) begin
                    nx_we    = 1'b1;
                    nx_waddr = TW'(r_tail);
                    nx_wdata = r_tid_k;
                end else if (r_req.action == mlprq_pkg::ACT_DEQUEUE) begin
                    hl_we             = 1'b1;
                    hl_wdata          = {n, (n_is ? r_tail : LNULL)};
                    n_nonempty[r_li]  = n_is;
                    pv_we             = n_is;
                    pv_waddr          = TW'(n);
                    pv_wdata          = LNULL;
                    n_linked[r_task]  = 1'b0;
                    n_rsp.result_task = mlprq_pkg::TASK_W'(r_task);
                end else begin
                    n_state = mlprq_pkg::S_DONE;
                end
            end
            mlprq_pkg::S_DONE: begin
                o_done = i_out_free;
                if (i_out_free) begin
                    n_state = mlprq_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mlprq_pkg::S_IDLE;
            r_linked   <= '0;
            r_nonempty <= '0;
        end else begin
            r_state    <= n_state;
            r_linked   <= n_linked;
            r_nonempty <= n_nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_rsp  <= n_rsp;
        r_tid  <= n_tid;
        r_li   <= n_li;
        r_tail <= n_tail;
        r_task <= n_task;
    end

    assign o_idle = r_state == mlprq_pkg::S_IDLE;
    assign o_rsp  = r_rsp;

`ifndef SYNTHESIS
    a_deq_unlinked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mlprq_pkg::S_DONE && r_req.action == mlprq_pkg::ACT_DEQUEUE
         && r_rsp.status == mlprq_pkg::ST_OK) |-> !r_linked[r_task])
        else $error("dequeued task still linked");

    a_enq_linked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mlprq_pkg::S_DONE && r_req.action == mlprq_pkg::ACT_ENQUEUE
         && r_rsp.status == mlprq_pkg::ST_OK) |-> (r_linked[r_tid] && r_nonempty[r_li]))
        else $error("enqueued task not linked into an occupied list");

    a_empty_deq_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mlprq_pkg::S_DONE && r_rsp.status == mlprq_pkg::ST_EMPTY)
        |-> r_req.action == mlprq_pkg::ACT_DEQUEUE)
        else $error("empty status on a non-dequeue transaction");

    a_step_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mlprq_pkg::S_STEP |-> $past(r_state) == mlprq_pkg::S_READ)
        else $error("second pointer step entered out of sequence");
`endif
endmodule

### design/multilevel_priority_ready_queue.sv
// Sequence: a rejected or unused action goes from idle straight to the done state;
// remove and enqueue onto an empty list pass the read state; enqueue onto a non-empty
// list and dequeue pass the read and step states. Done waits for a free output.
// Transactions are taken one at a time, only while the controller is idle, set by the
// pointer read-modify-write sequence through the link and head/tail memories.
// Reset: synchronous, active low; clears the linked and list-occupancy flags at once,
// with no clearing pass over the memories.
module multilevel_priority_ready_queue #(
    parameter int MAX_TASKS      = mlprq_pkg::MAX_TASKS_DEF,
    parameter int NUM_PRIORITIES = mlprq_pkg::NUM_PRIORITIES_DEF,
    parameter int NUM_STATES     = mlprq_pkg::NUM_STATES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mlprq_stream_if.sink          i_req,
    mlprq_stream_if.source        o_rsp
);
    logic            ctrl_idle;
    logic            ctrl_done;
    logic            start;
    logic            out_free;
    mlprq_pkg::t_rsp ctrl_rsp;
    logic            r_out_valid;
    mlprq_pkg::t_rsp r_out;

    assign start    = i_req.valid && ctrl_idle;
    assign out_free = !r_out_valid || o_rsp.ready;

    mlprq_ctrl #(
        .MAX_TASKS      (MAX_TASKS),
        .NUM_PRIORITIES (NUM_PRIORITIES),
        .NUM_STATES     (NUM_STATES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (i_req.data),
        .i_out_free (out_free),
        .o_idle     (ctrl_idle),
        .o_done     (ctrl_done),
        .o_rsp      (ctrl_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl_done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl_done) begin
            r_out <= ctrl_rsp;
        end
    end

    assign i_req.ready = ctrl_idle;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;
endmodule
